>>> src/apg_pkg.sv
// Shared types, widths and register codes of the attitude and position guidance block.
package apg_pkg;

    localparam int POS_FRAC_BITS_DEF  = 16;
    localparam int QUAT_FRAC_BITS_DEF = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_TDIR_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TDIR_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TDIR_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_GAIN = 3'd5;

    localparam int LANES    = 3;
    localparam int MAS_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int DIFF_W   = 33;
    localparam int RAD_W    = 2 * DIFF_W;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int SPD_W    = 31;
    localparam int NUM_W    = DIFF_W + SPD_W;
    localparam int RATE_LAT = 7;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] goal_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pitch_rate;
        logic signed [31:0] yaw_rate;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               at_goal;
    } t_out;

endpackage

>>> src/attitude_position_guidance.sv
// Top level of the attitude and position guidance block.
// Input channel i_in_valid / o_in_ready / i_in_data carries one item: attitude
// quaternion, current position and goal position. Output channel o_out_valid /
// i_out_ready / o_out_data returns one item per input: pitch and yaw rate
// commands, the velocity vector and the at-goal flag.
// Configuration registers are written through i_cfg_wr_en, i_cfg_idx and
// i_cfg_wdata; unknown indexes are ignored. The user must write them only while
// no item is in flight; the block itself does not enforce this. One item can be
// accepted in every cycle while o_in_ready is high. The velocity path holds
// the 33-stage square root and the 31-stage divider; the rate path is delayed
// to match. Reset clears the config and valid registers, emptying the pipeline.
// When the receiver stalls, the output register holds its item and one more
// item is caught in a skid register; only then does o_in_ready fall and the
// whole pipeline hold still until the output is taken.
module attitude_position_guidance #(
    parameter int POS_FRAC_BITS  = apg_pkg::POS_FRAC_BITS_DEF,
    parameter int QUAT_FRAC_BITS = apg_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [apg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [apg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  apg_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output apg_pkg::t_out                    o_out_data
);
    import apg_pkg::*;

    localparam int VEL_LAT = 3 + ROOT_W + 3 + SPD_W + 1;
    localparam int DLY     = VEL_LAT - RATE_LAT;
    localparam int SQ_SDW  = LANES * DIFF_W;
    localparam int DV_SDW  = LANES + 1;

    logic signed [15:0] r_tdir [LANES];
    logic [MAS_W-1:0]   r_mas;
    logic [SPD_W-1:0]   r_mls;
    logic [GAIN_W-1:0]  r_gain;

    logic en;
    logic push;
    logic pop;
    t_out push_data;
    t_out r_o, r_s;
    logic r_ov, r_sv;

    t_quat quat;
    logic signed [31:0] pitch, yaw;
    logic [63:0] r_dly [DLY];

    logic                     r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic signed [DIFF_W-1:0] r_d1 [LANES];
    logic signed [DIFF_W-1:0] r_d2 [LANES];
    logic signed [DIFF_W-1:0] r_d3 [LANES];
    logic signed [DIFF_W-1:0] r_d4 [LANES];
    logic signed [RAD_W-1:0]  sq_n [LANES];
    logic [RAD_W-1:0]         r_sq [LANES];
    logic [RAD_W-1:0]         r_ss;

    logic                     sq_vld;
    logic [ROOT_W-1:0]        sq_root;
    logic [SQ_SDW-1:0]        sq_side;

    logic [GAIN_W+ROOT_W-1:0] r_prod;
    logic [GAIN_W+ROOT_W-1:0] prod_r;
    logic [ROOT_W-1:0]        r_root4, r_root5, r_root6;
    logic                     r_zero4, r_zero5, r_zero6, r_zero7;
    logic [SPD_W-1:0]         r_spd5;
    logic [DIFF_W-1:0]        r_mag5 [LANES];
    logic [LANES-1:0]         r_neg5, r_neg6;
    logic [NUM_W-1:0]         r_num6 [LANES];

    logic                     dv_vld;
    logic [SPD_W-1:0]         dv_quo [LANES];
    logic [DV_SDW-1:0]        dv_side;
    logic signed [31:0]       r_vel [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tdir[0] <= '0;
            r_tdir[1] <= '0;
            r_tdir[2] <= '0;
            r_mas     <= '0;
            r_mls     <= '0;
            r_gain    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_TDIR_X:   r_tdir[0] <= i_cfg_wdata[15:0];
                CFG_TDIR_Y:   r_tdir[1] <= i_cfg_wdata[15:0];
                CFG_TDIR_Z:   r_tdir[2] <= i_cfg_wdata[15:0];
                CFG_MAX_ANG:  r_mas     <= i_cfg_wdata[MAS_W-1:0];
                CFG_MAX_LIN:  r_mls     <= i_cfg_wdata[SPD_W-1:0];
                CFG_POS_GAIN: r_gain    <= i_cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign en         = !r_sv;
    assign o_in_ready = en;

    assign quat.w = i_in_data.quat_w;
    assign quat.x = i_in_data.quat_x;
    assign quat.y = i_in_data.quat_y;
    assign quat.z = i_in_data.quat_z;

    apg_rate #(
        .QF(QUAT_FRAC_BITS),
        .PF(POS_FRAC_BITS)
    ) u_rate (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_quat (quat),
        .i_tdir (r_tdir),
        .i_mas  (r_mas),
        .o_pitch(pitch),
        .o_yaw  (yaw)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= {pitch, yaw};
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= sq_vld;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= dv_vld;
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            sq_n[i] = r_d1[i] * r_d1[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= $signed({i_in_data.goal_x[31], i_in_data.goal_x})
                     - $signed({i_in_data.pos_x[31], i_in_data.pos_x});
            r_d1[1] <= $signed({i_in_data.goal_y[31], i_in_data.goal_y})
                     - $signed({i_in_data.pos_y[31], i_in_data.pos_y});
            r_d1[2] <= $signed({i_in_data.goal_z[31], i_in_data.goal_z})
                     - $signed({i_in_data.pos_z[31], i_in_data.pos_z});
            for (int i = 0; i < LANES; i++) begin
                r_sq[i] <= sq_n[i];
                r_d2[i] <= r_d1[i];
                r_d3[i] <= r_d2[i];
            end
            r_ss <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    apg_isqrt #(
        .IW (RAD_W),
        .SDW(SQ_SDW)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_v3),
        .i_rad  (r_ss),
        .i_side ({r_d3[0], r_d3[1], r_d3[2]}),
        .o_vld  (sq_vld),
        .o_root (sq_root),
        .o_side (sq_side)
    );

    assign prod_r = r_prod + (GAIN_W+ROOT_W)'(128);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod  <= r_gain * sq_root;
            r_root4 <= sq_root;
            r_zero4 <= (sq_root == '0);
            r_d4[0] <= sq_side[3*DIFF_W-1 -: DIFF_W];
            r_d4[1] <= sq_side[2*DIFF_W-1 -: DIFF_W];
            r_d4[2] <= sq_side[DIFF_W-1 -: DIFF_W];

            if (prod_r[GAIN_W+ROOT_W-1:8] > (GAIN_W+ROOT_W-8)'(r_mls)) begin
                r_spd5 <= r_mls;
            end else begin
                r_spd5 <= prod_r[SPD_W+7:8];
            end
            for (int i = 0; i < LANES; i++) begin
                r_mag5[i] <= r_d4[i][DIFF_W-1] ? DIFF_W'(-r_d4[i]) : DIFF_W'(r_d4[i]);
                r_neg5[i] <= r_d4[i][DIFF_W-1];
                r_num6[i] <= r_mag5[i] * r_spd5;
            end
            r_root5 <= r_root4;
            r_zero5 <= r_zero4;
            r_root6 <= r_root5;
            r_zero6 <= r_zero5;
            r_neg6  <= r_neg5;
        end
    end

    apg_div #(
        .NW (NUM_W),
        .DW (ROOT_W),
        .QW (SPD_W),
        .SDW(DV_SDW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_v6),
        .i_num  (r_num6),
        .i_den  (r_root6),
        .i_side ({r_zero6, r_neg6}),
        .o_vld  (dv_vld),
        .o_quo  (dv_quo),
        .o_side (dv_side)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero7 <= dv_side[LANES];
            for (int i = 0; i < LANES; i++) begin
                if (dv_side[LANES]) begin
                    r_vel[i] <= '0;
                end else if (dv_side[i]) begin
                    r_vel[i] <= 32'sd0 - $signed({1'b0, dv_quo[i]});
                end else begin
                    r_vel[i] <= $signed({1'b0, dv_quo[i]});
                end
            end
        end
    end

    always_comb begin
        push_data.pitch_rate = r_dly[DLY-1][63:32];
        push_data.yaw_rate   = r_dly[DLY-1][31:0];
        push_data.vel_x      = r_vel[0];
        push_data.vel_y      = r_vel[1];
        push_data.vel_z      = r_vel[2];
        push_data.at_goal    = r_zero7;
    end

    assign push = en && r_v7;
    assign pop  = r_ov && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || pop) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= push;
            end
        end else if (push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || pop) begin
            r_o <= r_sv ? r_s : push_data;
        end else if (push) begin
            r_s <= push_data;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_o;

endmodule

>>> src/apg_rate.sv
// Pipelined attitude rate path: quaternion axes, aim vector, dot products and rate scaling.
module apg_rate #(
    parameter int QF = apg_pkg::QUAT_FRAC_BITS_DEF,
    parameter int PF = apg_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  apg_pkg::t_quat      i_quat,
    input  logic signed [15:0]  i_tdir [apg_pkg::LANES],
    input  logic [15:0]         i_mas,
    output logic signed [31:0]  o_pitch,
    output logic signed [31:0]  o_yaw
);
    import apg_pkg::*;

    localparam int AXW = ((2 * QF > 32) ? 2 * QF : 32) + 3;
    localparam int RAX = AXW - QF;
    localparam int AMW = RAX + 1;
    localparam int CW  = QF + 2;
    localparam int CTW = CW + 17;
    localparam int RCW = CTW - QF;
    localparam int PW  = RAX + AMW;
    localparam int DTW = PW + 3;
    localparam int MW  = DTW + MAS_W + 1;
    localparam int K   = 2 * QF + 8 - PF;

    localparam logic [CW-1:0] C11 = CW'((11 * (64'd1 << QF) + 64'd5) / 64'd10);
    localparam logic signed [AXW-1:0] ONE     = {{(AXW-1){1'b0}}, 1'b1} << (2 * QF);
    localparam logic signed [AXW-1:0] AX_HALF = {{(AXW-1){1'b0}}, 1'b1} << (QF - 1);
    localparam logic signed [CTW-1:0] CT_HALF = {{(CTW-1){1'b0}}, 1'b1} << (QF - 1);
    localparam logic signed [MW-1:0]  R_HALF  = {{(MW-1){1'b0}}, 1'b1} << (K - 1);

    function automatic logic signed [RAX-1:0] rnd_axis(input logic signed [AXW-1:0] v);
        logic signed [AXW-1:0] s;
        s = v + AX_HALF;
        return s[AXW-1:QF];
    endfunction

    function automatic logic signed [31:0] sat_rate(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] s;
        logic signed [MW-1:0] sh;
        s  = v + R_HALF;
        sh = s >>> K;
        if ((&sh[MW-1:31]) || (~|sh[MW-1:31])) begin
            return sh[31:0];
        end else if (sh[MW-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    logic signed [31:0] r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz, r_pwx, r_pwy, r_pwz;
    logic signed [CTW-1:0] ct [LANES];
    logic signed [CTW-1:0] cts [LANES];
    logic signed [RCW-1:0] r_rct_a [LANES];
    logic signed [RCW-1:0] r_rct_b [LANES];
    logic signed [AXW-1:0] r_left [LANES];
    logic signed [AXW-1:0] r_up [LANES];
    logic signed [AXW-1:0] r_fwd [LANES];
    logic signed [RAX-1:0] r_rleft [LANES];
    logic signed [RAX-1:0] r_rup [LANES];
    logic signed [AMW-1:0] r_aim [LANES];
    logic signed [PW-1:0]  r_pu [LANES];
    logic signed [PW-1:0]  r_pl [LANES];
    logic signed [DTW-1:0] r_du, r_dl;
    logic signed [MW-1:0]  r_mu, r_ml;
    logic signed [31:0]    r_pitch, r_yaw;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            ct[i]  = $signed({1'b0, C11}) * i_tdir[i];
            cts[i] = ct[i] + CT_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxx <= i_quat.x * i_quat.x;
            r_pyy <= i_quat.y * i_quat.y;
            r_pzz <= i_quat.z * i_quat.z;
            r_pxy <= i_quat.x * i_quat.y;
            r_pxz <= i_quat.x * i_quat.z;
            r_pyz <= i_quat.y * i_quat.z;
            r_pwx <= i_quat.w * i_quat.x;
            r_pwy <= i_quat.w * i_quat.y;
            r_pwz <= i_quat.w * i_quat.z;
            for (int i = 0; i < LANES; i++) begin
                r_rct_a[i] <= cts[i][CTW-1:QF];
                r_rct_b[i] <= r_rct_a[i];
            end

            r_left[0] <= ONE - ((AXW'(r_pyy) + AXW'(r_pzz)) <<< 1);
            r_left[1] <= (AXW'(r_pxy) + AXW'(r_pwz)) <<< 1;
            r_left[2] <= (AXW'(r_pxz) - AXW'(r_pwy)) <<< 1;
            r_up[0]   <= (AXW'(r_pxy) - AXW'(r_pwz)) <<< 1;
            r_up[1]   <= ONE - ((AXW'(r_pxx) + AXW'(r_pzz)) <<< 1);
            r_up[2]   <= (AXW'(r_pyz) + AXW'(r_pwx)) <<< 1;
            r_fwd[0]  <= -((AXW'(r_pxz) + AXW'(r_pwy)) <<< 1);
            r_fwd[1]  <= -((AXW'(r_pyz) - AXW'(r_pwx)) <<< 1);
            r_fwd[2]  <= ((AXW'(r_pxx) + AXW'(r_pyy)) <<< 1) - ONE;

            for (int i = 0; i < LANES; i++) begin
                r_rleft[i] <= rnd_axis(r_left[i]);
                r_rup[i]   <= rnd_axis(r_up[i]);
                r_aim[i]   <= AMW'(rnd_axis(r_fwd[i])) + AMW'(r_rct_b[i]);
                r_pu[i]    <= r_rup[i] * r_aim[i];
                r_pl[i]    <= r_rleft[i] * r_aim[i];
            end

            r_du <= DTW'(r_pu[0]) + DTW'(r_pu[1]) + DTW'(r_pu[2]);
            r_dl <= -(DTW'(r_pl[0]) + DTW'(r_pl[1]) + DTW'(r_pl[2]));

            r_mu <= r_du * $signed({1'b0, i_mas});
            r_ml <= r_dl * $signed({1'b0, i_mas});

            r_pitch <= sat_rate(r_mu);
            r_yaw   <= sat_rate(r_ml);
        end
    end

    assign o_pitch = r_pitch;
    assign o_yaw   = r_yaw;

endmodule

>>> src/apg_isqrt.sv
// Pipelined integer square root, one root bit per stage, with side data carried along.
module apg_isqrt #(
    parameter int IW  = apg_pkg::RAD_W,
    parameter int SDW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [IW-1:0]   i_rad,
    input  logic [SDW-1:0]  i_side,
    output logic            o_vld,
    output logic [IW/2-1:0] o_root,
    output logic [SDW-1:0]  o_side
);
    import apg_pkg::*;

    localparam int OW = IW / 2;

    logic [IW-1:0]  r_rad  [OW];
    logic [OW:0]    r_rem  [OW];
    logic [OW-1:0]  r_root [OW];
    logic [SDW-1:0] r_side [OW];
    logic [OW-1:0]  r_vld;

    for (genvar k = 0; k < OW; k++) begin : g_stage
        logic [IW-1:0]  rad_in;
        logic [OW:0]    rem_in;
        logic [OW-1:0]  root_in;
        logic [SDW-1:0] side_in;
        logic           vld_in;
        logic [OW+2:0]  t;
        logic [OW+2:0]  trial;
        logic [OW+2:0]  diff;
        logic           ge;

        if (k == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign t     = {rem_in, rad_in[IW-1:IW-2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign diff  = t - trial;
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {rad_in[IW-3:0], 2'b00};
                r_rem[k]  <= ge ? diff[OW:0] : t[OW:0];
                r_root[k] <= {root_in[OW-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[OW-1];
    assign o_root = r_root[OW-1];
    assign o_side = r_side[OW-1];

endmodule

>>> src/apg_div.sv
// Pipelined unsigned divider for three lanes with a shared divisor, one quotient bit per stage.
module apg_div #(
    parameter int NW  = apg_pkg::NUM_W,
    parameter int DW  = apg_pkg::ROOT_W,
    parameter int QW  = apg_pkg::SPD_W,
    parameter int SDW = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [NW-1:0]  i_num [apg_pkg::LANES],
    input  logic [DW-1:0]  i_den,
    input  logic [SDW-1:0] i_side,
    output logic           o_vld,
    output logic [QW-1:0]  o_quo [apg_pkg::LANES],
    output logic [SDW-1:0] o_side
);
    import apg_pkg::*;

    logic [DW-1:0]  r_rem  [QW][LANES];
    logic [QW-1:0]  r_nq   [QW][LANES];
    logic [DW-1:0]  r_den  [QW];
    logic [SDW-1:0] r_side [QW];
    logic [QW-1:0]  r_vld;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0]  rem_in [LANES];
        logic [QW-1:0]  nq_in  [LANES];
        logic [DW-1:0]  den_in;
        logic [SDW-1:0] side_in;
        logic           vld_in;

        if (k == 0) begin : g_first
            for (genvar l = 0; l < LANES; l++) begin : g_ld
                assign rem_in[l] = i_num[l][NW-1:QW];
                assign nq_in[l]  = i_num[l][QW-1:0];
            end
            assign den_in  = i_den;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            for (genvar l = 0; l < LANES; l++) begin : g_ld
                assign rem_in[l] = r_rem[k-1][l];
                assign nq_in[l]  = r_nq[k-1][l];
            end
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DW:0] t;
            logic [DW:0] diff;
            logic        ge;

            assign t    = {rem_in[l], nq_in[l][QW-1]};
            assign diff = t - {1'b0, den_in};
            assign ge   = (t >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k][l] <= ge ? diff[DW-1:0] : t[DW-1:0];
                    r_nq[k][l]  <= {nq_in[l][QW-2:0], ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_nq[QW-1][l];
    end
    assign o_vld  = r_vld[QW-1];
    assign o_side = r_side[QW-1];

endmodule

>>> bench/apg_checker.sv
// Checker that predicts and compares every result item of the guidance block.
`timescale 1ns / 100ps
module apg_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [2:0]    i_cfg_idx,
    input  logic [30:0]   i_cfg_wdata,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  apg_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  apg_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_out_count
);
    import apg_pkg::*;

    localparam int QB = 14;
    localparam int PB = 16;

    logic signed [15:0] tdir [3];
    logic [15:0]        ang_scale;
    logic [30:0]        lin_limit;
    logic [15:0]        gain;
    t_out               cmd_queue [$];

    function automatic logic signed [63:0] rnd_q(input logic signed [63:0] v);
        rnd_q = (v + (64'sd1 <<< (QB - 1))) >>> QB;
    endfunction

    function automatic logic signed [31:0] rate_of(input logic signed [63:0] dot);
        logic signed [127:0] p;
        p = (128'(dot) * $signed({112'd0, ang_scale}) + (128'sd1 <<< (2 * QB + 7 - PB)))
            >>> (2 * QB + 8 - PB);
        if (p > 128'sd2147483647) rate_of = 32'h7FFFFFFF;
        else if (p < -128'sd2147483648) rate_of = 32'h80000000;
        else rate_of = p[31:0];
    endfunction

    function automatic t_out predict_cmd(input t_in it);
        logic signed [63:0] w, x, y, z, one, c11, aim, dup, dlf, t;
        logic signed [63:0] lf [3];
        logic signed [63:0] up [3];
        logic signed [63:0] fw [3];
        logic signed [63:0] d [3];
        logic [127:0] ss, lo, hi, mid;
        logic signed [127:0] root_d, spd, v;
        t_out r;
        w = 64'(it.quat_w); x = 64'(it.quat_x); y = 64'(it.quat_y); z = 64'(it.quat_z);
        one = 64'sd1 <<< (2 * QB);
        c11 = (64'sd11 * (64'sd1 <<< QB) + 64'sd5) / 64'sd10;
        lf[0] = one - 2 * (y * y + z * z); lf[1] = 2 * (x * y + w * z);
        lf[2] = 2 * (x * z - w * y);
        up[0] = 2 * (x * y - w * z); up[1] = one - 2 * (x * x + z * z);
        up[2] = 2 * (y * z + w * x);
        fw[0] = -2 * (x * z + w * y); fw[1] = -2 * (y * z - w * x);
        fw[2] = -(one - 2 * (x * x + y * y));
        dup = '0; dlf = '0;
        for (int i = 0; i < 3; i++) begin
            t = 64'(tdir[i]);
            aim = rnd_q(fw[i]) + rnd_q(c11 * t);
            dup += rnd_q(up[i]) * aim;
            dlf += rnd_q(lf[i]) * aim;
        end
        r.pitch_rate = rate_of(dup);
        r.yaw_rate = rate_of(-dlf);
        d[0] = 64'(it.goal_x) - 64'(it.pos_x);
        d[1] = 64'(it.goal_y) - 64'(it.pos_y);
        d[2] = 64'(it.goal_z) - 64'(it.pos_z);
        ss = '0;
        for (int i = 0; i < 3; i++) ss += 128'($signed(128'(d[i])) * $signed(128'(d[i])));
        lo = '0; hi = 128'd1 << 34;
        while (hi - lo > 128'd1) begin
            mid = lo + (hi - lo) / 128'd2;
            if (mid * mid <= ss) lo = mid; else hi = mid;
        end
        root_d = $signed(lo);
        if (root_d == 128'sd0) begin
            r.vel_x = '0; r.vel_y = '0; r.vel_z = '0; r.at_goal = 1'b1;
        end else begin
            spd = ($signed({112'd0, gain}) * root_d + 128'sd128) >>> 8;
            if (spd > $signed({97'd0, lin_limit})) spd = $signed({97'd0, lin_limit});
            v = 128'(d[0]) * spd / root_d; r.vel_x = v[31:0];
            v = 128'(d[1]) * spd / root_d; r.vel_y = v[31:0];
            v = 128'(d[2]) * spd / root_d; r.vel_z = v[31:0];
            r.at_goal = 1'b0;
        end
        return r;
    endfunction

    task automatic cmp(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $error("%s mismatch: expected %0d, actual %0d", nm, $signed(e), $signed(a));
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            tdir[0] <= '0; tdir[1] <= '0; tdir[2] <= '0;
            ang_scale <= '0; lin_limit <= '0; gain <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_TDIR_X:   tdir[0] <= i_cfg_wdata[15:0];
                    CFG_TDIR_Y:   tdir[1] <= i_cfg_wdata[15:0];
                    CFG_TDIR_Z:   tdir[2] <= i_cfg_wdata[15:0];
                    CFG_MAX_ANG:  ang_scale <= i_cfg_wdata[15:0];
                    CFG_MAX_LIN:  lin_limit <= i_cfg_wdata;
                    CFG_POS_GAIN: gain <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) cmd_queue.push_back(predict_cmd(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_out_count++;
                if (cmd_queue.size() == 0) begin
                    $error("Result item arrived with no expectation waiting.");
                    o_fail_count++;
                end else begin
                    e = cmd_queue.pop_front();
                    cmp("pitch_rate", e.pitch_rate, i_out_data.pitch_rate);
                    cmp("yaw_rate", e.yaw_rate, i_out_data.yaw_rate);
                    cmp("vel_x", e.vel_x, i_out_data.vel_x);
                    cmp("vel_y", e.vel_y, i_out_data.vel_y);
                    cmp("vel_z", e.vel_z, i_out_data.vel_z);
                    cmp("at_goal", 32'(e.at_goal), 32'(i_out_data.at_goal));
                end
            end
        end
        o_pending = cmd_queue.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_out_count = 0;
    end
endmodule

>>> bench/attitude_position_guidance_tb.sv
// Testbench top: stimulus, configuration phases and verdict for the guidance block.
`timescale 1ns / 100ps
module attitude_position_guidance_tb;
    import apg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    logic          clk = 0;
    logic          rst_n = 0;
    logic          cfg_wr_en = 0;
    logic [2:0]    cfg_idx = '0;
    logic [30:0]   cfg_wdata = '0;
    logic          in_valid = 0;
    logic          in_ready;
    t_in           in_data = '0;
    logic          out_valid;
    logic          out_ready = 0;
    t_out          out_data;
    int            fail_count, pending, out_count;
    int            idle_cycles = 0;
    int            items_sent = 0;
    bit            hold_off = 0;
    bit            stim_done = 0;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    attitude_position_guidance dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_wr_en(cfg_wr_en), .i_cfg_idx(cfg_idx),
        .i_cfg_wdata(cfg_wdata), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_in_data(in_data), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    apg_checker checker_u (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_wr_en(cfg_wr_en), .i_cfg_idx(cfg_idx),
        .i_cfg_wdata(cfg_wdata), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_in_data(in_data), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_data(out_data), .o_fail_count(fail_count), .o_pending(pending),
        .o_out_count(out_count)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) gap_len = 0;
        else if (r < 93) gap_len = $urandom_range(1, 3);
        else gap_len = $urandom_range(10, 60);
    endfunction

    always @(posedge clk) begin
        if (!rst_n || hold_off) out_ready <= 1'b0;
        else out_ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        cfg_wr_en <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send(input t_in it, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    function automatic logic signed [15:0] rnd_q14();
        case ($urandom_range(0, 5))
            0: rnd_q14 = 16'sd16384;
            1: rnd_q14 = -16'sd16384;
            2: rnd_q14 = 16'($urandom);
            default: rnd_q14 = 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_pos();
        case ($urandom_range(0, 4))
            0: rnd_pos = 32'($urandom);
            1: rnd_pos = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: rnd_pos = 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic t_in rnd_item();
        t_in it;
        int u;
        it.quat_w = rnd_q14(); it.quat_x = rnd_q14();
        it.quat_y = rnd_q14(); it.quat_z = rnd_q14();
        if ($urandom_range(0, 2) == 0) begin
            u = $urandom_range(0, 3);
            it.quat_w = u == 0 ? 16'sd16384 : 16'sd0;
            it.quat_x = u == 1 ? 16'sd16384 : 16'sd0;
            it.quat_y = u == 2 ? -16'sd16384 : 16'sd0;
            it.quat_z = u == 3 ? 16'sd16384 : 16'sd0;
        end
        it.pos_x = rnd_pos(); it.pos_y = rnd_pos(); it.pos_z = rnd_pos();
        it.goal_x = rnd_pos(); it.goal_y = rnd_pos(); it.goal_z = rnd_pos();
        if ($urandom_range(0, 9) == 0) begin
            it.goal_x = it.pos_x; it.goal_y = it.pos_y; it.goal_z = it.pos_z;
        end else if ($urandom_range(0, 5) == 0) begin
            it.goal_x = it.pos_x + 32'($signed($urandom_range(0, 4)) - 2);
            it.goal_y = it.pos_y; it.goal_z = it.pos_z;
        end
        return it;
    endfunction

    task automatic random_config(input int phase);
        write_reg(CFG_TDIR_X, 31'($urandom));
        write_reg(CFG_TDIR_Y, 31'($urandom));
        write_reg(CFG_TDIR_Z, 31'($urandom));
        write_reg(CFG_MAX_ANG, phase % 3 == 0 ? 31'hFFFF : 31'($urandom));
        write_reg(CFG_MAX_LIN, phase % 3 == 1 ? 31'h7FFFFFFF : 31'($urandom));
        write_reg(CFG_POS_GAIN, phase % 4 == 2 ? 31'hFFFF : 31'($urandom_range(0, 65535)));
        write_reg(CFG_UNMAPPED_HI, 31'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        t_in it;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed items with reset registers and then with extreme settings.
        for (int p = 0; p < 2; p++) begin
            if (p == 1) begin
                write_reg(CFG_TDIR_X, 31'h8000);
                write_reg(CFG_TDIR_Y, 31'h7FFF);
                write_reg(CFG_TDIR_Z, 31'h4000);
                write_reg(CFG_MAX_ANG, 31'hFFFF);
                write_reg(CFG_MAX_LIN, 31'h7FFFFFFF);
                write_reg(CFG_POS_GAIN, 31'hFFFF);
                write_reg(CFG_UNMAPPED_LO, 31'h1234);
                cfg_wr_en <= 1'b0;
            end
            it = '0; it.quat_w = 16'sd16384; send(it, 1'b0);
            it.goal_x = 32'h7FFFFFFF; it.pos_x = 32'h80000000;
            it.goal_y = 32'h80000000; it.pos_y = 32'h7FFFFFFF;
            it.goal_z = 32'h7FFFFFFF; it.pos_z = 32'h80000000; send(it, 1'b0);
            it.quat_w = -16'sd16384; it.quat_x = -16'sd16384; it.quat_y = 16'sd16384;
            it.quat_z = -16'sd16384; send(it, 1'b0);
            it.quat_w = 16'h7FFF; it.quat_x = 16'h8000; it.quat_y = 16'h7FFF;
            it.quat_z = 16'h8000; it.goal_x = 32'sd1; it.pos_x = '0;
            it.goal_y = '0; it.pos_y = '0; it.goal_z = '0; it.pos_z = '0; send(it, 1'b0);
            it.goal_x = -32'sd1; send(it, 1'b0);
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            random_config(ph);
            if (ph == 3) fork
                begin
                    hold_off = 1;
                    repeat (400) @(posedge clk);
                    hold_off = 0;
                end
            join_none
            for (int k = 0; k < 230; k++) send(rnd_item(), ph % 2);
            drain();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        $display("Sent %0d items over ten register settings, %0d results checked.",
                 items_sent, out_count);
        if (fail_count == 0 && pending == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> filelist.f
src/apg_pkg.sv
src/apg_rate.sv
src/apg_isqrt.sv
src/apg_div.sv
src/attitude_position_guidance.sv
bench/apg_checker.sv
bench/attitude_position_guidance_tb.sv
